// File: rtl/sfrc8_pkg.sv
// Package for the serial frame receiver with CRC-8 check.
// Holds frame constants, status codes, the phase type and the CRC byte step.
// No dependencies.
package sfrc8_pkg;

    localparam int MAX_PAYLOAD_DEFAULT = 12;

    // Payload bytes that reach the result: speeds, angle and control byte
    localparam int STORE_DEPTH = 9;
    localparam int STORE_IDX_W = 4;

    localparam logic [7:0] HDR0     = 8'h55;
    localparam logic [7:0] HDR1     = 8'hAA;
    localparam logic [7:0] CRC_POLY = 8'h8C;
    localparam logic [7:0] CRC_INIT = 8'h00;

    typedef enum logic [1:0] {
        STATUS_GOOD    = 2'd0,
        STATUS_CRC_ERR = 2'd1,
        STATUS_LEN_ERR = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        PH_HUNT    = 5'b00001,
        PH_LEN     = 5'b00010,
        PH_PAYLOAD = 5'b00100,
        PH_CRC     = 5'b01000,
        PH_TAIL    = 5'b10000
    } phase_t;

    // Reflected CRC-8, one byte per call
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // Running CRC after the two header bytes
    localparam logic [7:0] CRC_AFTER_HDR = crc8_byte(crc8_byte(CRC_INIT, HDR0), HDR1);

endpackage

// File: rtl/serial_frame_receiver_crc8_core.sv
// Top level of the serial frame receiver with CRC-8 check.
// Uses sfrc8_pkg for constants, phase type and the CRC byte step.
//
//  Channel | Direction | Handshake         | Payload
//  --------+-----------+-------------------+--------------------------------------------
//  in      | request   | in_valid/in_stall | rx_byte
//  out     | response  | out_valid/out_stall | status, motor1_speed, motor2_speed,
//          |           |                   | angle_bits, control_byte, frame_length
//
// One byte per cycle sustained while no stalled result blocks the parser. A byte sits in the
// input register, where the frame parser and CRC step act on it; a result is then captured
// in the output register.
// Reset (rst_n low, asynchronous) returns to header hunting and clears the payload
// bytes and the running CRC.
// A stalled result holds the output register; the input register then holds its
// byte and in_stall rises only while that register is full.
module serial_frame_receiver_crc8_core
    import sfrc8_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic signed [15:0] motor1_speed,
    output logic signed [15:0] motor2_speed,
    output logic [31:0]        angle_bits,
    output logic [7:0]         control_byte,
    output logic [7:0]         frame_length
);

    // Payload counter must hold MAX_PAYLOAD itself
    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // frame state
    phase_t           phase_reg, phase_next;
    logic [7:0]       prev_reg, prev_next;
    logic [7:0]       len_reg, len_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       crc_reg, crc_next;
    logic             tail_reg, tail_next;
    logic [7:0]       store_reg [STORE_DEPTH];

    // result register
    logic        out_valid_reg;
    status_t     status_reg;
    logic [15:0] m1_reg, m2_reg;
    logic [31:0] angle_reg;
    logic [7:0]  ctrl_reg, flen_reg;

    logic             advance;
    logic             in_accept;
    logic             res_fire;
    status_t          res_status;
    logic             res_good;
    logic [7:0]       crc_step;
    logic [CNT_W-1:0] cnt_inc;
    logic             store_we;

    // The parser moves whenever a byte is held and the result register can take a new value
    assign advance   = in_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall  = in_valid_reg && out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    assign crc_step = crc8_byte(crc_reg, in_byte_reg);
    assign cnt_inc  = cnt_reg + 1'b1;
    assign store_we = advance && (phase_reg == PH_PAYLOAD)
                      && (cnt_reg < CNT_W'(STORE_DEPTH));

    always_comb
    begin
        phase_next = phase_reg;
        prev_next  = prev_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        crc_next   = crc_reg;
        tail_next  = tail_reg;
        res_fire   = 1'b0;
        res_status = STATUS_GOOD;
        res_good   = 1'b0;
        unique case (phase_reg)
            PH_HUNT:
            begin
                if (in_byte_reg == HDR1 && prev_reg == HDR0)
                begin
                    crc_next   = CRC_AFTER_HDR;
                    cnt_next   = '0;
                    tail_next  = 1'b0;
                    phase_next = PH_LEN;
                end
                prev_next = in_byte_reg;
            end
            PH_LEN:
            begin
                len_next = in_byte_reg;
                crc_next = crc_step;
                if (in_byte_reg > 8'(MAX_PAYLOAD))
                begin
                    res_fire   = 1'b1;
                    res_status = STATUS_LEN_ERR;
                    phase_next = PH_HUNT;
                    prev_next  = '0;
                    cnt_next   = '0;
                    tail_next  = 1'b0;
                end
                else
                begin
                    cnt_next   = '0;
                    phase_next = (in_byte_reg == 8'd0) ? PH_CRC : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                crc_next = crc_step;
                cnt_next = cnt_inc;
                if (8'(cnt_inc) >= len_reg)
                    phase_next = PH_CRC;
            end
            PH_CRC:
            begin
                if (in_byte_reg != crc_reg)
                begin
                    res_fire   = 1'b1;
                    res_status = STATUS_CRC_ERR;
                    phase_next = PH_HUNT;
                    prev_next  = '0;
                    cnt_next   = '0;
                    tail_next  = 1'b0;
                end
                else
                begin
                    tail_next  = 1'b0;
                    phase_next = PH_TAIL;
                end
            end
            PH_TAIL:
            begin
                if (!tail_reg)
                    tail_next = 1'b1;
                else
                begin
                    res_fire   = 1'b1;
                    res_good   = 1'b1;
                    phase_next = PH_HUNT;
                    prev_next  = '0;
                    cnt_next   = '0;
                    tail_next  = 1'b0;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
                prev_next  = '0;
                cnt_next   = '0;
                tail_next  = 1'b0;
            end
        endcase
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_accept)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            in_byte_reg <= rx_byte;
    end

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            prev_reg  <= '0;
            len_reg   <= '0;
            cnt_reg   <= '0;
            crc_reg   <= CRC_INIT;
            tail_reg  <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            prev_reg  <= prev_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            crc_reg   <= crc_next;
            tail_reg  <= tail_next;
        end
    end

    // payload bytes; later positions of a long frame are never reported
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
                store_reg[i] <= '0;
        end
        else if (store_we)
            store_reg[cnt_reg[STORE_IDX_W-1:0]] <= in_byte_reg;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && res_fire)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_fire)
        begin
            status_reg <= res_status;
            flen_reg   <= len_next;
            if (res_good)
            begin
                m1_reg    <= {store_reg[1], store_reg[0]};
                m2_reg    <= {store_reg[3], store_reg[2]};
                angle_reg <= {store_reg[7], store_reg[6], store_reg[5], store_reg[4]};
                ctrl_reg  <= store_reg[8];
            end
            else
            begin
                m1_reg    <= '0;
                m2_reg    <= '0;
                angle_reg <= '0;
                ctrl_reg  <= '0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign motor1_speed = m1_reg;
    assign motor2_speed = m2_reg;
    assign angle_bits   = angle_reg;
    assign control_byte = ctrl_reg;
    assign frame_length = flen_reg;

endmodule

// File: rtl/sfrc8_checker.sv
// Port-level checks for the serial frame receiver with CRC-8 check.
// Uses sfrc8_pkg; bound to serial_frame_receiver_crc8_core below.
module sfrc8_checker
    import sfrc8_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [15:0] motor1_speed,
    input logic [15:0] motor2_speed,
    input logic [31:0] angle_bits,
    input logic [7:0]  control_byte,
    input logic [7:0]  frame_length
);

    // stalled response holds its valid, status and frame length
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(frame_length))
        else $error("stalled response dropped or changed");

    // error responses carry zero payload fields
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_GOOD |->
            motor1_speed == 16'd0 && motor2_speed == 16'd0 &&
            angle_bits == 32'd0 && control_byte == 8'd0)
        else $error("error response with payload data");

    // length error only for oversize frames
    a_len_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_LEN_ERR |-> frame_length > 8'(MAX_PAYLOAD))
        else $error("length error on legal length");

    // other responses only for legal lengths
    a_len_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_GOOD || status == STATUS_CRC_ERR) |->
            frame_length <= 8'(MAX_PAYLOAD))
        else $error("frame response with oversize length");

endmodule

bind serial_frame_receiver_crc8_core sfrc8_checker #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
) u_sfrc8_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .motor1_speed (motor1_speed),
    .motor2_speed (motor2_speed),
    .angle_bits   (angle_bits),
    .control_byte (control_byte),
    .frame_length (frame_length)
);
